>>> rtl/core/assert_macros.svh
// shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, off while reset is held
`define CHK_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// clocked check, also active during reset
`define CHK_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

>>> rtl/core/i2cm_pkg.sv
package i2cm_pkg;

    localparam int S_TDATA_W = 24;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 8;

    localparam int FIFO_DEPTH_DEF = 4;

    localparam logic [7:0] START_HOLD_RST  = 8'd4;
    localparam logic [7:0] BIT_PHASE_RST   = 8'd2;
    localparam logic [7:0] ACK_TIMEOUT_RST = 8'd250;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START_HOLD  = 2'd0,
        REG_BIT_PHASE   = 2'd1,
        REG_ACK_TIMEOUT = 2'd2
    } reg_index_t;

    typedef enum logic [2:0] {
        OP_NONE  = 3'd0,
        OP_START = 3'd1,
        OP_WRITE = 3'd2,
        OP_READ  = 3'd3,
        OP_STOP  = 3'd4
    } op_code_t;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_START,
        CMD_WRITE,
        CMD_READ,
        CMD_STOP
    } cmd_t;

    typedef struct packed {
        cmd_t       cmd;
        logic [6:0] address;
        logic       read_dir;
        logic [7:0] wr_data;
        logic       send_ack;
        logic       sda_in;
    } cmd_word_t;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_ST_A,
        PH_ST_B,
        PH_TX_LO,
        PH_TX_HI,
        PH_TX_END,
        PH_AK_LO,
        PH_AK_POLL,
        PH_RX_LO,
        PH_RX_HI,
        PH_RA_LO,
        PH_RA_HI,
        PH_SP_A,
        PH_SP_B
    } phase_t;

    function automatic logic [7:0] at_least_one(input logic [7:0] n);
        return (n == 8'd0) ? 8'd1 : n;
    endfunction

endpackage

>>> rtl/core/i2cm_front.sv
module i2cm_front (
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [i2cm_pkg::S_TUSER_W-1:0] s_tuser,
    input  logic [i2cm_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                           queue_full,
    output logic                           push,
    output i2cm_pkg::cmd_word_t            push_word
);
    import i2cm_pkg::*;

    cmd_t cmd;

    // classify the op code, unknown codes do nothing
    always_comb begin
        unique case (s_tuser)
            OP_START: cmd = CMD_START;
            OP_WRITE: cmd = CMD_WRITE;
            OP_READ:  cmd = CMD_READ;
            OP_STOP:  cmd = CMD_STOP;
            default:  cmd = CMD_NONE;
        endcase
    end

    assign s_tready = !queue_full;
    assign push     = s_tvalid && !queue_full;

    always_comb begin
        push_word.cmd      = cmd;
        push_word.address  = s_tdata[6:0];
        push_word.read_dir = s_tdata[7];
        push_word.wr_data  = s_tdata[15:8];
        push_word.send_ack = s_tdata[16];
        push_word.sda_in   = s_tdata[17];
    end

endmodule

>>> rtl/core/i2cm_queue.sv
module i2cm_queue #(
    parameter int DEPTH = i2cm_pkg::FIFO_DEPTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  i2cm_pkg::cmd_word_t push_word,
    output logic                full,
    input  logic                pop,
    output i2cm_pkg::cmd_word_t head,
    output logic                head_valid
);
    import i2cm_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    cmd_word_t     mem_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign full       = (count_reg == FULL_CNT);
    assign head_valid = (count_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + AW'(1);
        end
        unique case ({do_push, do_pop})
            2'b10:   count_next = count_reg + CW'(1);
            2'b01:   count_next = count_reg - CW'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_word;
        end
    end

endmodule

>>> rtl/core/i2cm_seq.sv
module i2cm_seq (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [i2cm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [i2cm_pkg::CFG_DATA_W-1:0] cfg_data,
    input  i2cm_pkg::cmd_word_t             head,
    input  logic                            head_valid,
    output logic                            pop,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [i2cm_pkg::M_TDATA_W-1:0]  m_tdata
);
    import i2cm_pkg::*;

    logic [7:0] start_hold_reg, bit_phase_reg, ack_timeout_reg;

    phase_t     phase_reg, phase_next;
    logic [7:0] tick_reg, tick_next;
    logic [3:0] bc_reg, bc_next;
    logic [7:0] shift_reg, shift_next;
    logic [7:0] poll_reg, poll_next;
    logic       scl_reg, scl_next;
    logic       sda_reg, sda_next;
    logic       oe_reg, oe_next;
    logic       done_reg, done_next;
    logic [7:0] rd_reg, rd_next;
    logic       err_reg, err_next;
    logic       ack_choice_reg, ack_choice_next;

    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    logic       consume;
    logic [7:0] sh_ticks, bp_ticks;
    logic       tick_last, bc_last, poll_over;

    assign consume   = head_valid && (!m_tvalid_reg || m_tready);
    assign pop       = consume;
    assign sh_ticks  = at_least_one(start_hold_reg);
    assign bp_ticks  = at_least_one(bit_phase_reg);
    assign tick_last = (tick_reg <= 8'd1);
    assign bc_last   = (bc_reg >= 4'd7);
    assign poll_over = (poll_reg >= ack_timeout_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_hold_reg  <= START_HOLD_RST;
            bit_phase_reg   <= BIT_PHASE_RST;
            ack_timeout_reg <= ACK_TIMEOUT_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_START_HOLD:  start_hold_reg  <= cfg_data;
                REG_BIT_PHASE:   bit_phase_reg   <= cfg_data;
                REG_ACK_TIMEOUT: ack_timeout_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // next state
    always_comb begin
        phase_next = phase_reg;
        tick_next  = tick_reg;
        if (consume) begin
            priority if (phase_reg == PH_IDLE) begin
                unique case (head.cmd)
                    CMD_START: begin phase_next = PH_ST_A;  tick_next = sh_ticks; end
                    CMD_WRITE: begin phase_next = PH_TX_LO; tick_next = bp_ticks; end
                    CMD_READ:  begin phase_next = PH_RX_LO; tick_next = bp_ticks; end
                    CMD_STOP:  begin phase_next = PH_SP_A;  tick_next = sh_ticks; end
                    default: ;
                endcase
            end else if (phase_reg == PH_AK_POLL) begin
                priority if (!head.sda_in) begin
                    phase_next = PH_IDLE;
                    tick_next  = 8'd0;
                end else if (poll_over) begin
                    phase_next = PH_SP_A;
                    tick_next  = sh_ticks;
                end else begin
                    // keep polling
                end
            end else if (!tick_last) begin
                tick_next = tick_reg - 8'd1;
            end else begin
                unique case (phase_reg)
                    PH_ST_A:   begin phase_next = PH_ST_B;  tick_next = sh_ticks; end
                    PH_ST_B:   begin phase_next = PH_TX_LO; tick_next = bp_ticks; end
                    PH_TX_LO:  begin phase_next = PH_TX_HI; tick_next = bp_ticks; end
                    PH_TX_HI:  begin phase_next = PH_TX_END; tick_next = bp_ticks; end
                    PH_TX_END: begin
                        phase_next = bc_last ? PH_AK_LO : PH_TX_LO;
                        tick_next  = bp_ticks;
                    end
                    PH_AK_LO:  begin phase_next = PH_AK_POLL; tick_next = 8'd1; end
                    PH_RX_LO:  begin phase_next = PH_RX_HI; tick_next = bp_ticks; end
                    PH_RX_HI:  begin
                        phase_next = bc_last ? PH_RA_LO : PH_RX_LO;
                        tick_next  = bp_ticks;
                    end
                    PH_RA_LO:  begin phase_next = PH_RA_HI; tick_next = bp_ticks; end
                    PH_SP_A:   begin phase_next = PH_SP_B;  tick_next = sh_ticks; end
                    default:   begin phase_next = PH_IDLE;  tick_next = 8'd0; end
                endcase
            end
        end
    end

    // line levels, shifter and status
    always_comb begin
        bc_next         = bc_reg;
        shift_next      = shift_reg;
        poll_next       = poll_reg;
        scl_next        = scl_reg;
        sda_next        = sda_reg;
        oe_next         = oe_reg;
        done_next       = done_reg;
        rd_next         = rd_reg;
        err_next        = err_reg;
        ack_choice_next = ack_choice_reg;
        if (consume) begin
            done_next = 1'b0;
            priority if (phase_reg == PH_IDLE) begin
                bc_next = 4'd0;
                unique case (head.cmd)
                    CMD_START: begin
                        err_next   = 1'b0;
                        shift_next = {head.address, head.read_dir};
                        oe_next    = 1'b1;
                        sda_next   = 1'b1;
                        scl_next   = 1'b1;
                    end
                    CMD_WRITE: begin
                        err_next   = 1'b0;
                        shift_next = head.wr_data;
                        scl_next   = 1'b0;
                        oe_next    = 1'b1;
                        sda_next   = head.wr_data[7];
                    end
                    CMD_READ: begin
                        ack_choice_next = head.send_ack;
                        shift_next      = 8'd0;
                        oe_next         = 1'b0;
                        scl_next        = 1'b0;
                    end
                    CMD_STOP: begin
                        oe_next  = 1'b1;
                        scl_next = 1'b0;
                        sda_next = 1'b0;
                    end
                    default: ;
                endcase
            end else if (phase_reg == PH_AK_POLL) begin
                priority if (!head.sda_in) begin
                    scl_next  = 1'b0;
                    done_next = 1'b1;
                end else if (poll_over) begin
                    err_next = 1'b1;
                    oe_next  = 1'b1;
                    scl_next = 1'b0;
                    sda_next = 1'b0;
                end else begin
                    poll_next = poll_reg + 8'd1;
                end
            end else if (!tick_last) begin
                // hold the lines through the phase
            end else begin
                unique case (phase_reg)
                    PH_ST_A: sda_next = 1'b0;
                    PH_ST_B: begin
                        scl_next = 1'b0;
                        oe_next  = 1'b1;
                        sda_next = shift_reg[7];
                    end
                    PH_TX_LO: scl_next = 1'b1;
                    PH_TX_HI: scl_next = 1'b0;
                    PH_TX_END: begin
                        shift_next = {shift_reg[6:0], 1'b0};
                        bc_next    = bc_reg + 4'd1;
                        scl_next   = 1'b0;
                        if (bc_last) begin
                            oe_next   = 1'b0;
                            poll_next = 8'd0;
                        end else begin
                            oe_next  = 1'b1;
                            sda_next = shift_reg[6];
                        end
                    end
                    PH_AK_LO: scl_next = 1'b1;
                    PH_RX_LO: scl_next = 1'b1;
                    PH_RX_HI: begin
                        shift_next = {shift_reg[6:0], head.sda_in};
                        bc_next    = bc_reg + 4'd1;
                        scl_next   = 1'b0;
                        if (bc_last) begin
                            oe_next  = 1'b1;
                            sda_next = !ack_choice_reg;
                        end
                    end
                    PH_RA_LO: scl_next = 1'b1;
                    PH_RA_HI: begin
                        scl_next  = 1'b0;
                        rd_next   = shift_reg;
                        done_next = 1'b1;
                    end
                    PH_SP_A: scl_next = 1'b1;
                    PH_SP_B: begin
                        sda_next  = 1'b1;
                        done_next = 1'b1;
                    end
                    default: done_next = 1'b1;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IDLE;
            tick_reg       <= 8'd0;
            bc_reg         <= 4'd0;
            shift_reg      <= 8'd0;
            poll_reg       <= 8'd0;
            scl_reg        <= 1'b1;
            sda_reg        <= 1'b1;
            oe_reg         <= 1'b1;
            done_reg       <= 1'b0;
            rd_reg         <= 8'd0;
            err_reg        <= 1'b0;
            ack_choice_reg <= 1'b0;
        end else begin
            phase_reg      <= phase_next;
            tick_reg       <= tick_next;
            bc_reg         <= bc_next;
            shift_reg      <= shift_next;
            poll_reg       <= poll_next;
            scl_reg        <= scl_next;
            sda_reg        <= sda_next;
            oe_reg         <= oe_next;
            done_reg       <= done_next;
            rd_reg         <= rd_next;
            err_reg        <= err_next;
            ack_choice_reg <= ack_choice_next;
        end
    end

    // output word register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (consume) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (consume) begin
            m_tdata_reg <= {2'b00, err_next, rd_next, done_next,
                            (phase_next != PH_IDLE), oe_next, sda_next, scl_next};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

>>> rtl/core/i2c_master_byte_engine_unit.sv
// channel   dir  ports                         contents
// s_        in   s_tvalid s_tready s_tuser     tuser: op; tdata: command fields, sda_in
//                s_tdata
// m_        out  m_tvalid m_tready m_tdata     bus levels and status, one word per tick
// cfg_      in   cfg_wr_en cfg_index cfg_data  timing registers, write only
//
// one input word per cycle while the queue is not full; each yields a registered result word
// back-end throughput is one sequencer step per cycle while a word waits and output is free
// synchronous active-low reset empties the queue, idles the sequencer, loads register defaults
// up to FIFO_DEPTH words queue up while m_tready is low, then s_tready drops
module i2c_master_byte_engine_unit #(
    parameter int FIFO_DEPTH = i2cm_pkg::FIFO_DEPTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // op
    input  logic [i2cm_pkg::S_TUSER_W-1:0]  s_tuser,
    // address[6:0], read_dir, wr_data[7:0], send_ack, sda_in, zero pad
    input  logic [i2cm_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // scl, sda_out, sda_oe, busy_res, done_res, rd_data[7:0], ack_error, zero pad
    output logic [i2cm_pkg::M_TDATA_W-1:0]  m_tdata,
    input  logic                            cfg_wr_en,
    input  logic [i2cm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [i2cm_pkg::CFG_DATA_W-1:0] cfg_data
);
    import i2cm_pkg::*;

    cmd_word_t push_word, head;
    logic      push, queue_full, pop, head_valid;

    i2cm_front u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tuser    (s_tuser),
        .s_tdata    (s_tdata),
        .queue_full (queue_full),
        .push       (push),
        .push_word  (push_word)
    );

    i2cm_queue #(
        .DEPTH (FIFO_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_word  (push_word),
        .full       (queue_full),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid)
    );

    i2cm_seq u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

>>> rtl/core/i2cm_checker.sv
`include "assert_macros.svh"

module i2cm_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [i2cm_pkg::M_TDATA_W-1:0] m_tdata
);
    import i2cm_pkg::*;

    // reset leaves the queue ready for input and no pending word
    `CHK_ASSERT_ALWAYS(a_reset_clear, aclk, !aresetn |=> (!m_tvalid && s_tready))

    // a completing word never reports busy
    `CHK_ASSERT(a_done_not_busy, aclk, aresetn, m_tvalid |-> !(m_tdata[4] && m_tdata[3]))

    // pad bits stay zero
    `CHK_ASSERT(a_pad_zero, aclk, aresetn, m_tvalid |-> (m_tdata[15:14] == 2'b00))

    // stalled result holds
    `CHK_ASSERT(a_out_hold, aclk, aresetn,
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))

    // an input word offered with no output pending and no prior traffic is taken
    `CHK_ASSERT(a_idle_ready, aclk, aresetn,
        ($past(!m_tvalid) && !m_tvalid && $past(!s_tvalid)) |-> s_tready)

endmodule

bind i2c_master_byte_engine_unit i2cm_checker u_i2cm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
